### rtl/rse_pkg.sv
// ----------------------------------------------------------------------------
// rse_pkg
// Shared types, constants and token decode for the rpn stack evaluator.
// ----------------------------------------------------------------------------
`default_nettype none

package rse_pkg;

    localparam int STACK_DEPTH_DEF = 128;
    localparam int DATA_W          = 32;

    localparam logic [7:0] CH_ZERO  = 8'd48;
    localparam logic [7:0] CH_NINE  = 8'd57;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_EQUAL = 8'h3D;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_OVERFLOW  = 3'd1,
        ST_UNDERFLOW = 3'd2,
        ST_INVALID   = 3'd3,
        ST_DIVZERO   = 3'd4
    } status_t;

    typedef enum logic [2:0] {
        TK_DIGIT,
        TK_ADD,
        TK_SUB,
        TK_MUL,
        TK_DIV,
        TK_EQ,
        TK_BAD
    } tok_kind_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_DIV
    } state_t;

    typedef struct packed {
        logic      load_tok;
        logic      push;
        logic      alu;
        logic      div_start;
        logic      div_write;
        logic      clear;
        logic      emit;
        status_t   emit_status;
    } dp_cmd_t;

    typedef struct packed {
        tok_kind_t kind;
        logic      count_zero;
        logic      count_lt2;
        logic      count_full;
        logic      rhs_zero;
        logic      div_done;
        logic      out_free;
    } dp_stat_t;

    function automatic tok_kind_t classify(input logic [7:0] tok);
        tok_kind_t k;
        unique case (tok) inside
            [CH_ZERO:CH_NINE]: k = TK_DIGIT;
            CH_PLUS:           k = TK_ADD;
            CH_MINUS:          k = TK_SUB;
            CH_STAR:           k = TK_MUL;
            CH_SLASH:          k = TK_DIV;
            CH_EQUAL:          k = TK_EQ;
            default:           k = TK_BAD;
        endcase
        return k;
    endfunction

endpackage

`default_nettype wire

### rtl/rpn_stack_evaluator.sv
// ----------------------------------------------------------------------------
// rpn_stack_evaluator
// Reverse-polish integer evaluator over a bounded stack of 32-bit values.
//
//   channel  | direction | handshake                    | payload
//   ---------+-----------+------------------------------+----------------
//   token    | in        | token_valid / token_ready    | token[7:0]
//   result   | out       | result_valid / result_ready  | value, status
//
// a digit, + - * and = take an accept step, then one execute step
// a divide adds a divide step after its execute step, waiting on the one-bit-per-cycle divider
// stack entries below the top sit in a single-port memory, top in a register
// reset empties the stack at once; the memory is never cleared
// a result waits in the output register; a token that must emit while it is
// still full holds in its execute step until result_ready frees it
// ----------------------------------------------------------------------------
`default_nettype none

module rpn_stack_evaluator #(
    parameter int STACK_DEPTH = rse_pkg::STACK_DEPTH_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          token_valid,
    output logic                               token_ready,
    input  wire logic [7:0]                    token,
    output logic                               result_valid,
    input  wire logic                          result_ready,
    output logic signed [rse_pkg::DATA_W-1:0]  value,
    output logic [2:0]                         status
);

    rse_pkg::dp_cmd_t  cmd;
    rse_pkg::dp_stat_t stat;

    rse_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .token_valid (token_valid),
        .token_ready (token_ready),
        .stat        (stat),
        .cmd         (cmd)
    );

    rse_dp #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .token        (token),
        .result_ready (result_ready),
        .cmd          (cmd),
        .stat         (stat),
        .result_valid (result_valid),
        .value        (value),
        .status       (status)
    );

endmodule

`default_nettype wire

### rtl/rse_div.sv
// ----------------------------------------------------------------------------
// rse_div
// Signed 32-bit divider, one quotient bit per cycle, truncates toward zero.
// ----------------------------------------------------------------------------
`default_nettype none

module rse_div (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    input  wire logic [rse_pkg::DATA_W-1:0]    dividend,
    input  wire logic [rse_pkg::DATA_W-1:0]    divisor,
    output logic                               done,
    output logic [rse_pkg::DATA_W-1:0]         quotient
);

    localparam int W  = rse_pkg::DATA_W;
    localparam int NW = $clog2(W);

    logic            busy_reg, busy_next;
    logic            done_reg, done_next;
    logic [NW-1:0]   cnt_reg, cnt_next;
    logic [W-1:0]    rem_reg, rem_next;
    logic [W-1:0]    quo_reg, quo_next;
    logic [W-1:0]    den_reg, den_next;
    logic            neg_reg, neg_next;

    logic [W-1:0]    a_mag;
    logic [W-1:0]    b_mag;
    logic [W:0]      shifted;
    logic [W:0]      trial;

    assign a_mag   = dividend[W-1] ? (~dividend + W'(1)) : dividend;
    assign b_mag   = divisor[W-1]  ? (~divisor  + W'(1)) : divisor;
    assign shifted = {rem_reg, quo_reg[W-1]};
    assign trial   = shifted - {1'b0, den_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        den_next  = den_reg;
        neg_next  = neg_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = '0;
            quo_next  = a_mag;
            den_next  = b_mag;
            neg_next  = dividend[W-1] ^ divisor[W-1];
        end
        else if (busy_reg)
        begin
            if (!trial[W])
            begin
                rem_next = trial[W-1:0];
                quo_next = {quo_reg[W-2:0], 1'b1};
            end
            else
            begin
                rem_next = shifted[W-1:0];
                quo_next = {quo_reg[W-2:0], 1'b0};
            end
            cnt_next = cnt_reg + NW'(1);
            if (cnt_reg == NW'(W-1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        den_reg <= den_next;
        neg_reg <= neg_next;
    end

    assign done     = done_reg;
    assign quotient = neg_reg ? (~quo_reg + W'(1)) : quo_reg;

endmodule

`default_nettype wire

### rtl/rse_dp.sv
// ----------------------------------------------------------------------------
// rse_dp
// Datapath: token register, stack memory with top entry in a register,
// alu, divider and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module rse_dp #(
    parameter int STACK_DEPTH = rse_pkg::STACK_DEPTH_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic [7:0]                    token,
    input  wire logic                          result_ready,
    input  wire rse_pkg::dp_cmd_t              cmd,
    output rse_pkg::dp_stat_t                  stat,
    output logic                               result_valid,
    output logic signed [rse_pkg::DATA_W-1:0]  value,
    output logic [2:0]                         status
);

    localparam int W  = rse_pkg::DATA_W;
    localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int CW = $clog2(STACK_DEPTH + 1);

    logic [W-1:0]   mem [STACK_DEPTH];

    logic [7:0]     tok_reg;
    logic [W-1:0]   rd_data_reg;
    logic [W-1:0]   tos_reg, tos_next;
    logic [CW-1:0]  count_reg, count_next;
    logic           rv_reg, rv_next;
    logic [W-1:0]   val_reg;
    logic [2:0]     sts_reg;

    rse_pkg::tok_kind_t kind;
    logic [AW-1:0]  rd_addr;
    logic [AW-1:0]  wr_addr;
    logic [W-1:0]   alu_res;
    logic [W-1:0]   prod;
    logic           div_done;
    logic [W-1:0]   div_quo;

    assign kind    = rse_pkg::classify(tok_reg);
    assign rd_addr = AW'(count_reg - CW'(2));
    assign wr_addr = AW'(count_reg - CW'(1));
    assign prod    = rd_data_reg * tos_reg;

    always_comb
    begin
        case (kind)
            rse_pkg::TK_ADD: alu_res = rd_data_reg + tos_reg;
            rse_pkg::TK_SUB: alu_res = rd_data_reg - tos_reg;
            default:         alu_res = prod;
        endcase
    end

    rse_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (rd_data_reg),
        .divisor  (tos_reg),
        .done     (div_done),
        .quotient (div_quo)
    );

    always_comb
    begin
        tos_next   = tos_reg;
        count_next = count_reg;
        if (cmd.push)
        begin
            tos_next   = W'(tok_reg - rse_pkg::CH_ZERO);
            count_next = count_reg + CW'(1);
        end
        else if (cmd.alu)
        begin
            tos_next   = alu_res;
            count_next = count_reg - CW'(1);
        end
        else if (cmd.div_write)
        begin
            tos_next   = div_quo;
            count_next = count_reg - CW'(1);
        end
        else if (cmd.clear)
        begin
            count_next = '0;
        end
    end

    always_comb
    begin
        rv_next = rv_reg;
        if (cmd.emit)
        begin
            rv_next = 1'b1;
        end
        else if (result_ready)
        begin
            rv_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.push && (count_reg != '0))
        begin
            mem[wr_addr] <= tos_reg;
        end
        if (cmd.load_tok)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_tok)
        begin
            tok_reg <= token;
        end
        tos_reg <= tos_next;
        if (cmd.emit)
        begin
            val_reg <= (cmd.emit_status == rse_pkg::ST_OK) ? tos_reg : '0;
            sts_reg <= cmd.emit_status;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            rv_reg    <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            rv_reg    <= rv_next;
        end
    end

    assign stat.kind       = kind;
    assign stat.count_zero = (count_reg == '0);
    assign stat.count_lt2  = (count_reg < CW'(2));
    assign stat.count_full = (count_reg == CW'(STACK_DEPTH));
    assign stat.rhs_zero   = (tos_reg == '0);
    assign stat.div_done   = div_done;
    assign stat.out_free   = !rv_reg || result_ready;

    assign result_valid = rv_reg;
    assign value        = val_reg;
    assign status       = sts_reg;

endmodule

`default_nettype wire

### rtl/rse_ctrl.sv
// ----------------------------------------------------------------------------
// rse_ctrl
// Controller: sequences token accept, execute and divide steps.
// ----------------------------------------------------------------------------
`default_nettype none

module rse_ctrl (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               token_valid,
    output logic                    token_ready,
    input  wire rse_pkg::dp_stat_t  stat,
    output rse_pkg::dp_cmd_t        cmd
);

    rse_pkg::state_t  state_reg, state_next;
    logic             exec_emit;
    logic             exec_div;
    rse_pkg::status_t exec_status;

    // what the held token does in the execute step
    always_comb
    begin
        exec_emit   = 1'b0;
        exec_div    = 1'b0;
        exec_status = rse_pkg::ST_OK;
        unique case (stat.kind) inside
            rse_pkg::TK_DIGIT:
            begin
                exec_emit   = stat.count_full;
                exec_status = rse_pkg::ST_OVERFLOW;
            end
            rse_pkg::TK_ADD, rse_pkg::TK_SUB, rse_pkg::TK_MUL:
            begin
                exec_emit   = stat.count_lt2;
                exec_status = rse_pkg::ST_UNDERFLOW;
            end
            rse_pkg::TK_DIV:
            begin
                exec_emit   = stat.count_lt2 || stat.rhs_zero;
                exec_status = stat.count_lt2 ? rse_pkg::ST_UNDERFLOW : rse_pkg::ST_DIVZERO;
                exec_div    = !stat.count_lt2 && !stat.rhs_zero;
            end
            rse_pkg::TK_EQ:
            begin
                exec_emit   = 1'b1;
                exec_status = stat.count_zero ? rse_pkg::ST_UNDERFLOW : rse_pkg::ST_OK;
            end
            default:
            begin
                exec_emit   = 1'b1;
                exec_status = rse_pkg::ST_INVALID;
            end
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            rse_pkg::S_IDLE:
            begin
                if (token_valid)
                begin
                    state_next = rse_pkg::S_EXEC;
                end
            end
            rse_pkg::S_EXEC:
            begin
                if (exec_emit)
                begin
                    if (stat.out_free)
                    begin
                        state_next = rse_pkg::S_IDLE;
                    end
                end
                else if (exec_div)
                begin
                    state_next = rse_pkg::S_DIV;
                end
                else
                begin
                    state_next = rse_pkg::S_IDLE;
                end
            end
            rse_pkg::S_DIV:
            begin
                if (stat.div_done)
                begin
                    state_next = rse_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = rse_pkg::S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        token_ready     = 1'b0;
        cmd             = '0;
        cmd.emit_status = rse_pkg::ST_OK;
        unique case (state_reg)
            rse_pkg::S_IDLE:
            begin
                token_ready  = 1'b1;
                cmd.load_tok = token_valid;
            end
            rse_pkg::S_EXEC:
            begin
                if (exec_emit)
                begin
                    if (stat.out_free)
                    begin
                        cmd.emit        = 1'b1;
                        cmd.clear       = 1'b1;
                        cmd.emit_status = exec_status;
                    end
                end
                else if (exec_div)
                begin
                    cmd.div_start = 1'b1;
                end
                else if (stat.kind == rse_pkg::TK_DIGIT)
                begin
                    cmd.push = 1'b1;
                end
                else
                begin
                    cmd.alu = 1'b1;
                end
            end
            rse_pkg::S_DIV:
            begin
                cmd.div_write = stat.div_done;
            end
            default:
            begin
                token_ready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= rse_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

### rtl/rse_chk.sv
// ----------------------------------------------------------------------------
// rse_chk
// Port-level checks for the rpn stack evaluator, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module rse_chk (
    input wire logic                          clk,
    input wire logic                          rst_n,
    input wire logic                          token_valid,
    input wire logic                          token_ready,
    input wire logic [7:0]                    token,
    input wire logic                          result_valid,
    input wire logic                          result_ready,
    input wire logic signed [rse_pkg::DATA_W-1:0] value,
    input wire logic [2:0]                    status
);

    // held result stays put
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(value) && $stable(status))
        else $error("result changed while stalled");

    // a waiting token stays put
    a_token_hold: assert property (@(posedge clk) disable iff (!rst_n)
        token_valid && !token_ready |=> token_valid && $stable(token))
        else $error("token changed while waiting");

    // error results carry a zero value
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (status != rse_pkg::ST_OK) |-> (value == '0))
        else $error("error result with nonzero value");

    a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (status <= 3'(rse_pkg::ST_DIVZERO)))
        else $error("status code out of range");

    // an accepted item always gets an execute step before the next accept
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        token_valid && token_ready |=> !token_ready)
        else $error("token accepted on back-to-back cycles");

endmodule

bind rpn_stack_evaluator rse_chk u_chk (.*);

`default_nettype wire

### sim/rse_checker.sv
// ----------------------------------------------------------------------------
// rse_checker
// Watches the token and result channels of the rpn stack evaluator. Keeps a
// private copy of the operand stack and, for every accepted token, works out
// whether an item is due on the result side and what it holds. Each accepted
// result is compared field by field with the oldest outstanding one.
// ----------------------------------------------------------------------------
`default_nettype none

module rse_checker #(
    parameter int STACK_DEPTH = rse_pkg::STACK_DEPTH_DEF
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              token_valid,
    input  wire logic                              token_ready,
    input  wire logic [7:0]                        token,
    input  wire logic                              result_valid,
    input  wire logic                              result_ready,
    input  wire logic signed [rse_pkg::DATA_W-1:0] value,
    input  wire logic [2:0]                        status,
    output int                                     error_count,
    output int                                     pending
);

    typedef struct packed {
        logic [rse_pkg::DATA_W-1:0] value;
        rse_pkg::status_t           status;
    } outcome_t;

    logic [rse_pkg::DATA_W-1:0] stack_mem [STACK_DEPTH];
    int unsigned                stack_fill = 0;
    outcome_t                   outcome_q [$];
    int                         fail_tally = 0;

    task automatic report(input string msg);
        $display("rse_checker: mismatch: %s", msg);
        fail_tally++;
    endtask

    task automatic evaluate(input logic [7:0] t, output bit emits, output outcome_t r);
        logic [rse_pkg::DATA_W-1:0] lhs;
        logic [rse_pkg::DATA_W-1:0] rhs;
        logic [rse_pkg::DATA_W-1:0] res;
        longint                     quot;
        emits    = 1'b1;
        r.value  = '0;
        r.status = rse_pkg::ST_OK;
        if (t >= rse_pkg::CH_ZERO && t <= rse_pkg::CH_NINE)
        begin
            if (stack_fill >= STACK_DEPTH)
            begin
                stack_fill = 0;
                r.status   = rse_pkg::ST_OVERFLOW;
            end
            else
            begin
                stack_mem[stack_fill] = rse_pkg::DATA_W'(t - rse_pkg::CH_ZERO);
                stack_fill++;
                emits = 1'b0;
            end
        end
        else if (t == rse_pkg::CH_PLUS || t == rse_pkg::CH_MINUS ||
                 t == rse_pkg::CH_STAR || t == rse_pkg::CH_SLASH)
        begin
            if (stack_fill < 2)
            begin
                stack_fill = 0;
                r.status   = rse_pkg::ST_UNDERFLOW;
            end
            else
            begin
                rhs = stack_mem[stack_fill - 1];
                lhs = stack_mem[stack_fill - 2];
                if (t == rse_pkg::CH_SLASH && rhs == '0)
                begin
                    stack_fill = 0;
                    r.status   = rse_pkg::ST_DIVZERO;
                end
                else
                begin
                    case (t)
                        rse_pkg::CH_PLUS:  res = lhs + rhs;
                        rse_pkg::CH_MINUS: res = lhs - rhs;
                        rse_pkg::CH_STAR:  res = lhs * rhs;
                        default:
                        begin
                            // 64-bit quotient so the most negative / -1 wraps cleanly
                            quot = longint'(signed'(lhs)) / longint'(signed'(rhs));
                            res  = quot[rse_pkg::DATA_W-1:0];
                        end
                    endcase
                    stack_fill = stack_fill - 2;
                    stack_mem[stack_fill] = res;
                    stack_fill++;
                    emits = 1'b0;
                end
            end
        end
        else if (t == rse_pkg::CH_EQUAL)
        begin
            if (stack_fill == 0)
                r.status = rse_pkg::ST_UNDERFLOW;
            else
                r.value = stack_mem[stack_fill - 1];
            stack_fill = 0;
        end
        else
        begin
            stack_fill = 0;
            r.status   = rse_pkg::ST_INVALID;
        end
    endtask

    always @(posedge clk)
    begin : watch
        outcome_t want;
        outcome_t got;
        bit       emits;
        if (!rst_n)
        begin
            stack_fill = 0;
            outcome_q.delete();
        end
        else
        begin
            if (result_valid && result_ready)
            begin
                if (outcome_q.size() == 0)
                    report($sformatf("unexpected result value %0d status %0d",
                                     value, status));
                else
                begin
                    want = outcome_q.pop_front();
                    if (value !== want.value)
                        report($sformatf("value %0d, expected %0d",
                                         value, $signed(want.value)));
                    if (status !== want.status)
                        report($sformatf("status %0d, expected %0d",
                                         status, want.status));
                end
            end
            if (token_valid && token_ready)
            begin
                evaluate(token, emits, got);
                if (emits)
                    outcome_q.push_back(got);
            end
        end
        pending     <= outcome_q.size();
        error_count <= fail_tally;
    end

endmodule

`default_nettype wire

### sim/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Drives tokens into the rpn stack evaluator: directed expressions for the
// arithmetic corners and every error, then random well-formed expressions
// with some noise, under three idle patterns and one long result stall.
// The checker beside the block does the prediction and comparison.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;

    localparam int HOLD_CYCLES    = 400;
    localparam int PHASE_ITEMS    = 350;
    localparam int TIMEOUT_CYCLES = 400000;

    localparam logic [7:0] OP_CHARS [4] = '{rse_pkg::CH_PLUS, rse_pkg::CH_MINUS,
                                            rse_pkg::CH_STAR, rse_pkg::CH_SLASH};

    logic                              clk          = 1'b0;
    logic                              rst_n        = 1'b0;
    logic                              token_valid  = 1'b0;
    logic [7:0]                        token        = '0;
    logic                              result_ready = 1'b0;
    logic                              token_ready;
    logic                              result_valid;
    logic signed [rse_pkg::DATA_W-1:0] value;
    logic [2:0]                        status;

    int   error_count;
    int   pending;
    int   send_idle    = 0;
    int   recv_idle    = 0;
    int   items_sent   = 0;
    int   stall_left   = 0;
    logic stall_toggle = 1'b0;
    logic stall_seen   = 1'b0;

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    rpn_stack_evaluator i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .token_valid  (token_valid),
        .token_ready  (token_ready),
        .token        (token),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .value        (value),
        .status       (status)
    );

    rse_checker i_check (
        .clk          (clk),
        .rst_n        (rst_n),
        .token_valid  (token_valid),
        .token_ready  (token_ready),
        .token        (token),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .value        (value),
        .status       (status),
        .error_count  (error_count),
        .pending      (pending)
    );

    // result side: random back-pressure, or a long hold when requested
    always @(posedge clk)
    begin
        stall_seen <= stall_toggle;
        if (stall_toggle != stall_seen)
        begin
            stall_left   <= HOLD_CYCLES;
            result_ready <= 1'b0;
        end
        else if (stall_left != 0)
        begin
            stall_left   <= stall_left - 1;
            result_ready <= 1'b0;
        end
        else
            result_ready <= ($urandom_range(99) >= recv_idle);
    end

    task automatic send_tok(input logic [7:0] t);
        while ($urandom_range(99) < send_idle)
        begin
            token_valid <= 1'b0;
            @(posedge clk);
        end
        token_valid <= 1'b1;
        token       <= t;
        do
            @(posedge clk);
        while (!token_ready);
        items_sent++;
    endtask

    task automatic send_digit(input int d);
        send_tok(rse_pkg::CH_ZERO + 8'(d));
    endtask

    task automatic drain();
        token_valid <= 1'b0;
        do
            @(posedge clk);
        while (pending != 0);
    endtask

    // random expression, mostly well formed, with occasional junk
    task automatic send_expr();
        int digits_left;
        int depth;
        int pick;
        depth = 0;
        if ($urandom_range(99) == 0)
            digits_left = $urandom_range(135, 120);
        else
            digits_left = $urandom_range(12, 1);
        while (digits_left > 0 || depth > 1)
        begin
            if ($urandom_range(99) < 2)
            begin
                send_tok(8'($urandom_range(255)));
            end
            if (depth >= 2 && (digits_left == 0 || $urandom_range(1) == 0))
            begin
                send_tok(OP_CHARS[$urandom_range(3)]);
                depth--;
            end
            else
            begin
                send_digit($urandom_range(9));
                depth++;
                digits_left--;
            end
        end
        pick = $urandom_range(99);
        if (pick < 85)
            send_tok(rse_pkg::CH_EQUAL);
        else if (pick < 93)
            send_tok(OP_CHARS[$urandom_range(3)]);
    endtask

    task automatic run_directed();
        send_digit(3); send_digit(4); send_tok(rse_pkg::CH_PLUS);
        send_tok(rse_pkg::CH_EQUAL);
        send_digit(2); send_digit(9); send_tok(rse_pkg::CH_MINUS);
        send_tok(rse_pkg::CH_EQUAL);
        send_digit(9); send_digit(9); send_tok(rse_pkg::CH_STAR);
        send_tok(rse_pkg::CH_EQUAL);
        send_digit(0); send_digit(7); send_tok(rse_pkg::CH_MINUS); send_digit(2);
        send_tok(rse_pkg::CH_SLASH); send_tok(rse_pkg::CH_EQUAL);
        send_digit(5); send_digit(0); send_tok(rse_pkg::CH_SLASH);
        send_tok(rse_pkg::CH_PLUS);
        send_digit(5); send_tok(rse_pkg::CH_STAR);
        send_tok(rse_pkg::CH_EQUAL);
        send_digit(1); send_tok(8'h00);
        send_tok(8'h20);
        send_tok(8'hFF);
        // 8^10 * 2 wraps to the most negative value, then divide by -1
        send_digit(8);
        repeat (9)
        begin
            send_digit(8);
            send_tok(rse_pkg::CH_STAR);
        end
        send_digit(2); send_tok(rse_pkg::CH_STAR);
        send_digit(0); send_digit(1); send_tok(rse_pkg::CH_MINUS);
        send_tok(rse_pkg::CH_SLASH); send_tok(rse_pkg::CH_EQUAL);
        // full stack pops fine, one digit past full overflows
        repeat (128)
            send_digit($urandom_range(9));
        send_tok(rse_pkg::CH_EQUAL);
        repeat (129)
            send_digit($urandom_range(9));
    endtask

    task automatic run_pressure();
        stall_toggle <= ~stall_toggle;
        repeat (30)
        begin
            if ($urandom_range(1) == 0)
                send_tok(rse_pkg::CH_EQUAL);
            else
                send_tok(8'($urandom_range(255)));
        end
        drain();
    endtask

    task automatic run_random(input int s_idle, input int r_idle);
        int stop_at;
        send_idle = s_idle;
        recv_idle <= r_idle;
        stop_at = items_sent + PHASE_ITEMS;
        while (items_sent < stop_at)
            send_expr();
        drain();
    endtask

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        run_directed();
        drain();
        run_pressure();
        run_random(9, 87);
        run_random(87, 9);
        run_random(0, 0);
        repeat (60) @(posedge clk);
        if (error_count == 0 && pending == 0)
            $display("tb_top: clean");
        else
            $display("tb_top: errors");
        $finish;
    end

    initial
    begin
        #(20 * TIMEOUT_CYCLES);
        $display("tb_top: errors");
        $finish;
    end

endmodule

`default_nettype wire
